// ===== rtl/adsreg_pkg.sv =====
// ---------------------------------------------------------------------------
// adsreg_pkg
// shared widths, register indexes and stage codes of the adsr envelope unit
// ---------------------------------------------------------------------------
package adsreg_pkg;

    // default fixed point and time widths
    localparam int FRACTION_BITS_DEF = 24;
    localparam int TIME_BITS_DEF     = 24;

    // field widths
    localparam int LEVEL_W      = 16;
    localparam int STAGE_W      = 3;
    localparam int CFG_DATA_W   = 24;
    localparam int CFG_INDEX_W  = 2;

    // headroom of the level accumulator above the level field
    localparam int ACC_HEAD_W   = 2;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SUSTAIN = 2'd3;

    // envelope stage codes
    localparam logic [STAGE_W-1:0] STG_IDLE    = 3'd0;
    localparam logic [STAGE_W-1:0] STG_ATTACK  = 3'd1;
    localparam logic [STAGE_W-1:0] STG_DECAY   = 3'd2;
    localparam logic [STAGE_W-1:0] STG_SUSTAIN = 3'd3;
    localparam logic [STAGE_W-1:0] STG_RELEASE = 3'd4;

endpackage

// ===== rtl/adsr_envelope_generator_unit.sv =====
// ---------------------------------------------------------------------------
// adsr_envelope_generator_unit
// linear attack / decay / sustain / release envelope, one sample per item
// ---------------------------------------------------------------------------
//
//  port group   dir   payload                                   handshake
//  s_*          in    tdata: gate_level[15:0]; tuser: restart   tvalid/tready
//  m_*          out   tdata: envelope[15:0]; tuser: stage[2:0]  tvalid/tready
//  cfg_*        in    index 0 attack, 1 decay, 2 release,       cfg_we only
//                     3 sustain; cfg_wdata low bits used
//
//  steps: an item with no slope change goes wait, step, emit; a gate edge
//    first runs the edge slope through the serial divider, and reaching the
//    peak runs the decay slope through it once more before emit
//  the serial divider makes one quotient bit a cycle
//  one item is in flight at a time; s_tready is high only while waiting
//  the finished item sits in the output register; the next item is taken
//    while it waits, and a stall only holds the last step until it drains
//  reset: synchronous, active low; clears stage, level, slope, previous gate
//    and all configuration registers
// ---------------------------------------------------------------------------
module adsr_envelope_generator_unit #(
    parameter int FRACTION_BITS = adsreg_pkg::FRACTION_BITS_DEF,
    parameter int TIME_BITS     = adsreg_pkg::TIME_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input item
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // [15:0] gate_level
    input  logic [0:0]                          s_tuser,   // [0] restart
    // result item
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // [15:0] envelope
    output logic [2:0]                          m_tuser,   // [2:0] stage
    // configuration writes
    input  logic                                cfg_we,
    input  logic [adsreg_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [adsreg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int LW     = adsreg_pkg::LEVEL_W;
    localparam int ACC_W  = FRACTION_BITS + LW + adsreg_pkg::ACC_HEAD_W;
    localparam int DIV_W  = ACC_W - 1;
    localparam int TIME_W = (TIME_BITS < adsreg_pkg::CFG_DATA_W) ?
                            TIME_BITS : adsreg_pkg::CFG_DATA_W;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [ACC_W:0] ROUND_HALF =
        {{(ACC_W-FRACTION_BITS+1){1'b0}}, 1'b1, {(FRACTION_BITS-1){1'b0}}};

    typedef enum logic [4:0] {
        ST_WAIT  = 5'b00001,   // ready for an item
        ST_EDGE  = 5'b00010,   // slope of a gate edge in the divider
        ST_STEP  = 5'b00100,   // level update and stage change
        ST_PEAK  = 5'b01000,   // decay slope in the divider
        ST_EMIT  = 5'b10000    // hand the item to the output register
    } state_t;

    // configuration
    logic [TIME_W-1:0]               attack_reg;
    logic [TIME_W-1:0]               decay_reg;
    logic [TIME_W-1:0]               release_reg;
    logic [LW-1:0]                   sustain_reg;

    // envelope state
    state_t                          state_reg;
    logic [adsreg_pkg::STAGE_W-1:0]  phase_reg;
    logic [LW-1:0]                   prev_gate_reg;
    logic [LW-1:0]                   gate_reg;
    logic signed [ACC_W-1:0]         acc_reg;
    logic signed [ACC_W-1:0]         slope_reg;
    logic                            neg_reg;
    logic [LW-1:0]                   env_reg;

    // output register
    logic                            m_valid_reg;
    logic [LW-1:0]                   m_env_reg;
    logic [adsreg_pkg::STAGE_W-1:0]  m_stage_reg;

    // divider hookup
    logic                            div_start;
    logic [DIV_W-1:0]                div_dividend;
    logic [TIME_W-1:0]               div_divisor;
    logic                            div_done;
    logic [DIV_W-1:0]                div_quotient;
    logic signed [ACC_W-1:0]         div_slope;

    // combinational step
    logic                            accept;
    logic [LW-1:0]                   in_gate;
    logic                            rise;
    logic                            fall;
    logic signed [ACC_W-1:0]         gate_fx;
    logic signed [ACC_W-1:0]         sus_fx;
    logic signed [ACC_W:0]           sum_ext;
    logic signed [ACC_W-1:0]         sig_sat;
    logic signed [ACC_W-1:0]         sig_fin;
    logic signed [ACC_W-1:0]         dec_diff;
    logic [ACC_W-1:0]                dec_mag;
    logic                            at_peak;
    logic [adsreg_pkg::STAGE_W-1:0]  phase_step;
    logic                            clear_slope;
    logic [ACC_W:0]                  rnd;
    logic [LW-1:0]                   env_step;
    logic                            out_load;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_WAIT);
    assign in_gate  = s_tdata[LW-1:0];

    // new attack on a rising gate or a restart, release on a falling gate
    assign rise = ((in_gate != '0) && (prev_gate_reg == '0)) || s_tuser[0];
    assign fall = (in_gate == '0) && (prev_gate_reg != '0);

    assign gate_fx = {{adsreg_pkg::ACC_HEAD_W{1'b0}}, gate_reg, {FRACTION_BITS{1'b0}}};
    assign sus_fx  = {{adsreg_pkg::ACC_HEAD_W{1'b0}}, sustain_reg, {FRACTION_BITS{1'b0}}};

    // level plus slope, saturated to the accumulator range
    assign sum_ext = {acc_reg[ACC_W-1], acc_reg} + {slope_reg[ACC_W-1], slope_reg};
    always_comb begin
        if (sum_ext[ACC_W] != sum_ext[ACC_W-1]) begin
            sig_sat = sum_ext[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            sig_sat = sum_ext[ACC_W-1:0];
        end
    end

    // decay runs from the overshoot point toward sustain, either direction
    assign dec_diff = sig_sat - sus_fx;
    assign dec_mag  = dec_diff[ACC_W-1] ? ACC_W'(-dec_diff) : ACC_W'(dec_diff);

    always_comb begin
        phase_step  = phase_reg;
        sig_fin     = sig_sat;
        clear_slope = 1'b0;
        at_peak     = 1'b0;
        case (phase_reg)
            adsreg_pkg::STG_ATTACK: begin
                if (sig_sat >= gate_fx) begin
                    phase_step = adsreg_pkg::STG_DECAY;
                    at_peak    = 1'b1;
                end
            end
            adsreg_pkg::STG_DECAY: begin
                if (sig_sat <= sus_fx) begin
                    phase_step  = adsreg_pkg::STG_SUSTAIN;
                    clear_slope = 1'b1;
                end
            end
            adsreg_pkg::STG_RELEASE: begin
                if (sig_sat <= 0) begin
                    phase_step  = adsreg_pkg::STG_IDLE;
                    sig_fin     = '0;
                    clear_slope = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // round half up to the envelope lsb, then saturate
    assign rnd = {1'b0, sig_fin} + ROUND_HALF;
    always_comb begin
        if (sig_fin[ACC_W-1] || (sig_fin == '0)) begin
            env_step = '0;
        end else if (|rnd[ACC_W:FRACTION_BITS+LW]) begin
            env_step = adsreg_pkg::LEVEL_MAX;
        end else begin
            env_step = rnd[FRACTION_BITS+LW-1:FRACTION_BITS];
        end
    end

    // divider operands: edge slope at accept, decay slope at the peak
    always_comb begin
        div_start    = 1'b0;
        div_dividend = {1'b0, sustain_reg, {FRACTION_BITS{1'b0}}};
        div_divisor  = release_reg;
        if (state_reg == ST_WAIT) begin
            div_start = accept && (rise || fall);
            if (rise) begin
                div_dividend = {1'b0, in_gate, {FRACTION_BITS{1'b0}}};
                div_divisor  = attack_reg;
            end
        end else if (state_reg == ST_STEP) begin
            div_start    = at_peak;
            div_dividend = dec_mag[DIV_W-1:0];
            div_divisor  = decay_reg;
        end
    end

    assign div_slope = neg_reg ? -$signed({1'b0, div_quotient})
                               :  $signed({1'b0, div_quotient});

    adsreg_div #(
        .FRACTION_BITS (FRACTION_BITS),
        .DIVISOR_W     (TIME_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign out_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_reg  <= '0;
            decay_reg   <= '0;
            release_reg <= '0;
            sustain_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                adsreg_pkg::REG_ATTACK:  attack_reg  <= cfg_wdata[TIME_W-1:0];
                adsreg_pkg::REG_DECAY:   decay_reg   <= cfg_wdata[TIME_W-1:0];
                adsreg_pkg::REG_RELEASE: release_reg <= cfg_wdata[TIME_W-1:0];
                adsreg_pkg::REG_SUSTAIN: sustain_reg <= cfg_wdata[LW-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer and envelope state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_WAIT;
            phase_reg     <= adsreg_pkg::STG_IDLE;
            prev_gate_reg <= '0;
            acc_reg       <= '0;
            slope_reg     <= '0;
            neg_reg       <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_WAIT: begin
                    if (accept) begin
                        prev_gate_reg <= in_gate;
                        if (rise) begin
                            acc_reg   <= '0;
                            phase_reg <= adsreg_pkg::STG_ATTACK;
                            neg_reg   <= 1'b0;
                            state_reg <= ST_EDGE;
                        end else if (fall) begin
                            phase_reg <= adsreg_pkg::STG_RELEASE;
                            neg_reg   <= 1'b1;
                            state_reg <= ST_EDGE;
                        end else begin
                            state_reg <= ST_STEP;
                        end
                    end
                end
                ST_EDGE: begin
                    if (div_done) begin
                        slope_reg <= div_slope;
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    acc_reg   <= sig_fin;
                    phase_reg <= phase_step;
                    if (clear_slope) begin
                        slope_reg <= '0;
                    end
                    if (at_peak) begin
                        // level at or above sustain ramps down
                        neg_reg   <= ~dec_diff[ACC_W-1];
                        state_reg <= ST_PEAK;
                    end else begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_PEAK: begin
                    if (div_done) begin
                        slope_reg <= div_slope;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_load) begin
                        state_reg <= ST_WAIT;
                    end
                end
                default: begin
                    state_reg <= ST_WAIT;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_WAIT) && accept) begin
            gate_reg <= in_gate;
        end
        if (state_reg == ST_STEP) begin
            env_reg <= env_step;
        end
        if (out_load) begin
            m_env_reg   <= env_reg;
            m_stage_reg <= phase_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_env_reg;
    assign m_tuser  = m_stage_reg;

endmodule

// ===== rtl/adsreg_div.sv =====
// ---------------------------------------------------------------------------
// adsreg_div
// bit-serial restoring divider for slope magnitudes, capped at full scale
// ---------------------------------------------------------------------------
module adsreg_div #(
    parameter int FRACTION_BITS = adsreg_pkg::FRACTION_BITS_DEF,
    parameter int DIVISOR_W     = adsreg_pkg::TIME_BITS_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         start,
    input  logic [FRACTION_BITS+adsreg_pkg::LEVEL_W:0]   dividend,
    input  logic [DIVISOR_W-1:0]                         divisor,
    output logic                                         done,
    output logic [FRACTION_BITS+adsreg_pkg::LEVEL_W:0]   quotient
);

    localparam int DIV_W = FRACTION_BITS + adsreg_pkg::LEVEL_W + 1;
    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam logic [DIV_W-1:0] FULL_SCALE =
        {1'b0, adsreg_pkg::LEVEL_MAX, {FRACTION_BITS{1'b0}}};

    logic                 run_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dsr_reg;
    logic                 zero_reg;

    logic [DIVISOR_W:0]   rem_shift;
    logic [DIVISOR_W+1:0] trial;
    logic                 qbit;

    // one quotient bit per cycle, msb first
    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, dsr_reg};
    assign qbit      = ~trial[DIVISOR_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(DIV_W);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
            zero_reg <= (dividend == '0);
        end else if (run_reg) begin
            quo_reg <= {quo_reg[DIV_W-2:0], qbit};
            rem_reg <= qbit ? trial[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
        end
    end

    // a zero dividend gives zero slope whatever the divisor
    // a zero divisor gives all ones, which the cap turns into full scale
    assign done     = done_reg;
    assign quotient = zero_reg ? '0 : ((quo_reg > FULL_SCALE) ? FULL_SCALE : quo_reg);

endmodule

// ===== rtl/adsreg_chk.sv =====
// ---------------------------------------------------------------------------
// adsreg_chk
// port-level checks of the adsr envelope unit, bound to the top level
// ---------------------------------------------------------------------------
module adsreg_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // one item in flight: no second accept right after one
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready again right after accept");

    // the idle stage always comes with a zero envelope
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == adsreg_pkg::STG_IDLE) |-> (m_tdata == 16'd0))
        else $error("nonzero envelope in idle stage");

endmodule

bind adsr_envelope_generator_unit adsreg_chk u_adsreg_chk (.*);
